// File: sv/toy_spn_ctr_keystream_cipher_defines.svh
// Assertion macros for the toy SPN counter-mode keystream cipher.
// Relies on clk_i and rst_ni being visible in the asserting module.
`ifndef TOY_SPN_CTR_KEYSTREAM_CIPHER_DEFINES_SVH
`define TOY_SPN_CTR_KEYSTREAM_CIPHER_DEFINES_SVH

// Clocked check, switched off while reset is applied
`define TSPN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is applied
`define TSPN_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/tspn_pkg.sv
// Shared types, constants and helper functions of the toy SPN keystream cipher.
// No dependencies; used by the interfaces and the top-level module.
`default_nettype none

package tspn_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BLOCK_W  = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned PERM_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW  = 8;

  localparam logic [BYTE_W-1:0] KX_CONST_A = 8'h80;
  localparam logic [BYTE_W-1:0] KX_CONST_B = 8'h30;
  localparam logic [PERM_W-1:0] PERM_RESET = 24'hFAC688;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_BLOCK = 2'd2
  } action_e;

  typedef enum logic {
    CFG_KEY  = 1'b0,
    CFG_PERM = 1'b1
  } cfg_idx_e;

  // One state per S-box read after the first, plus idle and result hand-off
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KX2,
    ST_KX3,
    ST_R0B1,
    ST_R1B0,
    ST_R1B1,
    ST_R2B0,
    ST_R2B1,
    ST_DONE
  } state_e;

  // Exchange the two nibbles of a byte
  function automatic logic [BYTE_W-1:0] nib_swap(input logic [BYTE_W-1:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  // Output bit i copies the input bit chosen by 3-bit field i of the map
  function automatic logic [BYTE_W-1:0] bit_perm(input logic [BYTE_W-1:0] v,
                                                 input logic [PERM_W-1:0] map);
    logic [BYTE_W-1:0] y;
    y = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      y[i] = v[map[3*i +: 3]];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// File: sv/tspn_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Field widths come from tspn_pkg.
`default_nettype none

interface tspn_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [tspn_pkg::BYTE_W-1:0]  sbox_index;
  logic [tspn_pkg::BYTE_W-1:0]  sbox_value;
  logic [tspn_pkg::BYTE_W-1:0]  nonce_in;
  logic [tspn_pkg::BLOCK_W-1:0] data_block;

  modport source (output valid, action, sbox_index, sbox_value, nonce_in, data_block,
                  input ready);
  modport sink   (input valid, action, sbox_index, sbox_value, nonce_in, data_block,
                  output ready);
endinterface

interface tspn_out_if;
  logic                         valid;
  logic                         ready;
  logic [tspn_pkg::BLOCK_W-1:0] out_block;
  logic [tspn_pkg::BYTE_W-1:0]  block_counter;

  modport source (output valid, out_block, block_counter, input ready);
  modport sink   (input valid, out_block, block_counter, output ready);
endinterface

`default_nettype wire

// File: sv/tspn_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module tspn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry; read data holds while the port is idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/toy_spn_ctr_keystream_cipher.sv
// Toy 16-bit SPN cipher in counter mode: top level with sequencer and datapath.
// Depends on tspn_pkg, tspn_if.sv, tspn_ram and the assertion macro header.
//
// Three request kinds arrive on in_i: an S-box entry load, a message start
// (new nonce, counter cleared) and a data block. Loads and starts complete on
// acceptance. A block runs through the key expansion and round states to the
// result register; a new request is taken in the cycle its result is stored,
// so blocks do not overlap, and the single S-box RAM port sets the block rate:
// every block needs eight dependent reads (two for key expansion, two per
// round for three rounds). Results sit in an output register, so the engine
// carries on while out_o is stalled until the next result is due. The S-box
// has no reset and must be loaded before any entry it reads; the user must
// write cipher_key and perm_map only while idle; the block does not enforce it.
`default_nettype none
`include "toy_spn_ctr_keystream_cipher_defines.svh"

module toy_spn_ctr_keystream_cipher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [tspn_pkg::CFG_W-1:0]  cfg_wdata_i,
  tspn_in_if.sink                          in_i,
  tspn_out_if.source                       out_o
);

  tspn_pkg::state_e          state_q, state_d;
  tspn_pkg::action_e         act;

  logic [tspn_pkg::KEY_W-1:0]   key_q;
  logic [tspn_pkg::PERM_W-1:0]  perm_q;
  logic [tspn_pkg::BYTE_W-1:0]  nonce_q, counter_q;
  logic [tspn_pkg::BYTE_W-1:0]  w2_q, w3_q, w4_q, w5_q;
  logic [tspn_pkg::BYTE_W-1:0]  b0_q, b1_q, used_ctr_q;
  logic [tspn_pkg::BLOCK_W-1:0] data_q;
  logic                         out_valid_q;
  logic [tspn_pkg::BLOCK_W-1:0] out_block_q;
  logic [tspn_pkg::BYTE_W-1:0]  out_ctr_q;

  logic                         in_fire, out_free, finish;
  logic                         ram_en, ram_we;
  logic [tspn_pkg::SBOX_AW-1:0] ram_addr;
  logic [tspn_pkg::BYTE_W-1:0]  ram_rdata, perm_rdata;
  logic [tspn_pkg::BYTE_W-1:0]  key_hi, key_lo;
  logic [tspn_pkg::BYTE_W-1:0]  w2_d, w3_d, w4_d, w5_d;

  assign act     = tspn_pkg::action_e'(in_i.action);
  assign key_hi  = key_q[15:8];
  assign key_lo  = key_q[7:0];

  // Handshakes
  assign out_free    = !out_valid_q || out_o.ready;
  assign finish      = (state_q == tspn_pkg::ST_DONE) && out_free;
  assign in_i.ready  = (state_q == tspn_pkg::ST_IDLE) || finish;
  assign in_fire     = in_i.valid && in_i.ready;

  // Key expansion words from the S-box read data
  assign w2_d       = key_hi ^ tspn_pkg::KX_CONST_A ^ ram_rdata;
  assign w3_d       = w2_d ^ key_lo;
  assign w4_d       = w2_q ^ tspn_pkg::KX_CONST_B ^ ram_rdata;
  assign w5_d       = w4_d ^ w3_q;
  assign perm_rdata = tspn_pkg::bit_perm(ram_rdata, perm_q);

  // S-box storage
  tspn_ram #(
    .WIDTH (tspn_pkg::BYTE_W),
    .DEPTH (tspn_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.sbox_value),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      tspn_pkg::ST_IDLE: begin
        if (in_fire && act == tspn_pkg::ACT_BLOCK) state_d = tspn_pkg::ST_KX2;
      end
      tspn_pkg::ST_KX2:  state_d = tspn_pkg::ST_KX3;
      tspn_pkg::ST_KX3:  state_d = tspn_pkg::ST_R0B1;
      tspn_pkg::ST_R0B1: state_d = tspn_pkg::ST_R1B0;
      tspn_pkg::ST_R1B0: state_d = tspn_pkg::ST_R1B1;
      tspn_pkg::ST_R1B1: state_d = tspn_pkg::ST_R2B0;
      tspn_pkg::ST_R2B0: state_d = tspn_pkg::ST_R2B1;
      tspn_pkg::ST_R2B1: state_d = tspn_pkg::ST_DONE;
      tspn_pkg::ST_DONE: begin
        if (finish) begin
          state_d = (in_fire && act == tspn_pkg::ACT_BLOCK) ? tspn_pkg::ST_KX2
                                                             : tspn_pkg::ST_IDLE;
        end
      end
      default: state_d = tspn_pkg::ST_IDLE;
    endcase
  end

  // RAM port control: one read per sequencer step, loads on acceptance
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state_q)
      tspn_pkg::ST_IDLE, tspn_pkg::ST_DONE: begin
        if (in_fire) begin
          case (act)
            tspn_pkg::ACT_LOAD: begin
              ram_en   = 1'b1;
              ram_we   = 1'b1;
              ram_addr = in_i.sbox_index;
            end
            tspn_pkg::ACT_BLOCK: begin
              ram_en   = 1'b1;
              ram_addr = tspn_pkg::nib_swap(key_lo);
            end
            default: ram_en = 1'b0;
          endcase
        end
      end
      tspn_pkg::ST_KX2: begin
        ram_en   = 1'b1;
        ram_addr = tspn_pkg::nib_swap(w3_d);
      end
      tspn_pkg::ST_KX3: begin
        ram_en   = 1'b1;
        ram_addr = b0_q ^ key_hi;
      end
      tspn_pkg::ST_R0B1: begin
        ram_en   = 1'b1;
        ram_addr = b1_q ^ key_lo;
      end
      tspn_pkg::ST_R1B0: begin
        ram_en   = 1'b1;
        ram_addr = b0_q ^ w2_q;
      end
      tspn_pkg::ST_R1B1: begin
        ram_en   = 1'b1;
        ram_addr = b1_q ^ w3_q;
      end
      tspn_pkg::ST_R2B0: begin
        ram_en   = 1'b1;
        ram_addr = b0_q ^ w4_q;
      end
      tspn_pkg::ST_R2B1: begin
        ram_en   = 1'b1;
        ram_addr = b1_q ^ w5_q;
      end
      default: ram_en = 1'b0;
    endcase
  end

  // Control state: sequencer, configuration, nonce, counter, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tspn_pkg::ST_IDLE;
      key_q       <= '0;
      perm_q      <= tspn_pkg::PERM_RESET;
      nonce_q     <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (tspn_pkg::cfg_idx_e'(cfg_idx_i))
          tspn_pkg::CFG_KEY:  key_q  <= cfg_wdata_i[tspn_pkg::KEY_W-1:0];
          tspn_pkg::CFG_PERM: perm_q <= cfg_wdata_i[tspn_pkg::PERM_W-1:0];
          default: key_q <= key_q;
        endcase
      end
      if (in_fire) begin
        case (act)
          tspn_pkg::ACT_START: begin
            nonce_q   <= in_i.nonce_in;
            counter_q <= '0;
          end
          tspn_pkg::ACT_BLOCK: counter_q <= counter_q + 8'd1;
          default: counter_q <= counter_q;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: capture block request, expanded key and round bytes
  always_ff @(posedge clk_i) begin
    if (in_fire && act == tspn_pkg::ACT_BLOCK) begin
      b0_q       <= nonce_q;
      b1_q       <= counter_q;
      used_ctr_q <= counter_q;
      data_q     <= in_i.data_block;
    end else begin
      case (state_q)
        tspn_pkg::ST_KX2: begin
          w2_q <= w2_d;
          w3_q <= w3_d;
        end
        tspn_pkg::ST_KX3: begin
          w4_q <= w4_d;
          w5_q <= w5_d;
        end
        tspn_pkg::ST_R0B1, tspn_pkg::ST_R1B1, tspn_pkg::ST_R2B1: b0_q <= perm_rdata;
        tspn_pkg::ST_R1B0, tspn_pkg::ST_R2B0: b1_q <= perm_rdata;
        default: b0_q <= b0_q;
      endcase
    end
    if (finish) begin
      out_block_q <= {b0_q, perm_rdata} ^ data_q;
      out_ctr_q   <= used_ctr_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_block     = out_block_q;
  assign out_o.block_counter = out_ctr_q;

  // Checks on sequencing and counter behaviour
  `TSPN_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == tspn_pkg::ST_DONE), "result raised outside the final step")
  `TSPN_ASSERT(a_ctr_advance, (in_fire && act == tspn_pkg::ACT_BLOCK) |=> counter_q == 8'($past(counter_q) + 8'd1), "block counter did not advance")
  `TSPN_ASSERT(a_done_hold, (state_q == tspn_pkg::ST_DONE && !out_free) |=> (state_q == tspn_pkg::ST_DONE && $stable(ram_rdata)), "stalled final step lost its data")
  `TSPN_ASSERT_RST(a_reset_idle, !rst_ni |-> (!out_valid_q && state_q == tspn_pkg::ST_IDLE), "reset did not clear control")

endmodule

`default_nettype wire
